@@ rtl/acsf_pkg.sv @@
// Shared constants and types for the ATM call signalling state machine.
// Event codes, call state codes and the beat type passed between stages.
// No dependencies.
package acsf_pkg;

  localparam int ACT_W   = 5;
  localparam int REF_W   = 24;
  localparam int STATE_W = 4;
  localparam int CID_W   = 16;

  // Event codes.
  localparam logic [ACT_W-1:0] ACT_CONSTRUCT        = 5'd0;
  localparam logic [ACT_W-1:0] ACT_DESTROY          = 5'd1;
  localparam logic [ACT_W-1:0] ACT_LEAF_ADD         = 5'd2;
  localparam logic [ACT_W-1:0] ACT_LEAF_REMOVE      = 5'd3;
  localparam logic [ACT_W-1:0] ACT_LSR_RESPONSE     = 5'd4;
  localparam logic [ACT_W-1:0] ACT_LEAF_FAIL_IND    = 5'd5;
  localparam logic [ACT_W-1:0] ACT_LEAF_SETUP_IND   = 5'd6;
  localparam logic [ACT_W-1:0] ACT_PROCEEDING_IND   = 5'd7;
  localparam logic [ACT_W-1:0] ACT_CONNECT_IND      = 5'd8;
  localparam logic [ACT_W-1:0] ACT_RELEASE_IND      = 5'd9;
  localparam logic [ACT_W-1:0] ACT_REL_COMPLETE_IND = 5'd10;
  localparam logic [ACT_W-1:0] ACT_LEAF_SETUP_REQ   = 5'd11;
  localparam logic [ACT_W-1:0] ACT_LEAF_FAIL_REQ    = 5'd12;
  localparam logic [ACT_W-1:0] ACT_SETUP_REQ        = 5'd13;
  localparam logic [ACT_W-1:0] ACT_CONNECT_REQ      = 5'd14;
  localparam logic [ACT_W-1:0] ACT_RELEASE_REQ      = 5'd15;
  localparam logic [ACT_W-1:0] ACT_REL_COMPLETE_REQ = 5'd16;
  localparam logic [ACT_W-1:0] ACT_PASSTHROUGH      = 5'd17;
  localparam logic [ACT_W-1:0] ACT_DROP_ONLY        = 5'd18;
  localparam logic [ACT_W-1:0] ACT_RAW_PDU          = 5'd19;
  localparam logic [ACT_W-1:0] ACT_QUEUE_EMPTY      = 5'd20;
  localparam logic [ACT_W-1:0] ACT_UNKNOWN          = 5'd21;

  // Call states.
  localparam logic [STATE_W-1:0] ST_PREPARING     = 4'd0;
  localparam logic [STATE_W-1:0] ST_LIJ_PREPARING = 4'd1;
  localparam logic [STATE_W-1:0] ST_LIJ_REQUESTED = 4'd2;
  localparam logic [STATE_W-1:0] ST_IN_WAIT_LOCAL = 4'd3;
  localparam logic [STATE_W-1:0] ST_OUT_WAIT_REM  = 4'd4;
  localparam logic [STATE_W-1:0] ST_UNDERSPEC     = 4'd5;
  localparam logic [STATE_W-1:0] ST_P2P_ACTIVE    = 4'd6;
  localparam logic [STATE_W-1:0] ST_P2MP_ACTIVE   = 4'd7;
  localparam logic [STATE_W-1:0] ST_P2MP_LIJ      = 4'd8;
  localparam logic [STATE_W-1:0] ST_REL_INIT      = 4'd9;
  localparam logic [STATE_W-1:0] ST_RELEASED      = 4'd10;

  // Classified event as it travels from the front end to the executor.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             fatal_exempt;
    logic             p2p;
    logic             p2mp;
    logic             delayed;
    logic [REF_W-1:0] refv;
  } cmd_t;

endpackage

@@ rtl/acsf_if.sv @@
// Channel interfaces for the ATM call signalling state machine.
// Depends on acsf_pkg for field widths.
interface acsf_in_if;
  logic                        valid;
  logic                        ready;
  logic [acsf_pkg::ACT_W-1:0]  action;
  logic                        is_point_to_point;
  logic                        is_point_to_multipoint;
  logic                        delayed_setup_address;
  logic [acsf_pkg::REF_W-1:0]  reference_value;

  modport source (output valid, action, is_point_to_point, is_point_to_multipoint,
                  delayed_setup_address, reference_value, input ready);
  modport sink (input valid, action, is_point_to_point, is_point_to_multipoint,
                delayed_setup_address, reference_value, output ready);
endinterface

interface acsf_out_if;
  logic                          valid;
  logic                          ready;
  logic [acsf_pkg::STATE_W-1:0]  call_state;
  logic                          pass_on;
  logic                          wrong_state;
  logic                          duplicate_construct;
  logic                          fatal_after_destroy;
  logic                          destroyed_now;
  logic [acsf_pkg::REF_W-1:0]    stored_reference;

  modport source (output valid, call_state, pass_on, wrong_state, duplicate_construct,
                  fatal_after_destroy, destroyed_now, stored_reference, input ready);
  modport sink (input valid, call_state, pass_on, wrong_state, duplicate_construct,
                fatal_after_destroy, destroyed_now, stored_reference, output ready);
endinterface

@@ rtl/acsf_front.sv @@
// Front end: accepts input beats, classifies the event code and registers it.
// Depends on acsf_pkg and acsf_in_if.
module acsf_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  acsf_in_if.sink         in_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output acsf_pkg::cmd_t  cmd_o
);

  logic           valid_q;
  acsf_pkg::cmd_t cmd_q;
  acsf_pkg::cmd_t cmd_d;
  logic           accept;

  assign in_i.ready = !valid_q || cmd_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  // Codes with no effect of their own are folded into one code so the
  // executor only decodes what it acts on.
  always_comb begin
    cmd_d.act = in_i.action;
    if (in_i.action == acsf_pkg::ACT_DROP_ONLY || in_i.action == acsf_pkg::ACT_RAW_PDU ||
        in_i.action > acsf_pkg::ACT_QUEUE_EMPTY) begin
      cmd_d.act = acsf_pkg::ACT_UNKNOWN;
    end
    cmd_d.fatal_exempt = (in_i.action == acsf_pkg::ACT_CONSTRUCT) ||
                         (in_i.action == acsf_pkg::ACT_QUEUE_EMPTY);
    cmd_d.p2p     = in_i.is_point_to_point;
    cmd_d.p2mp    = in_i.is_point_to_multipoint;
    cmd_d.delayed = in_i.delayed_setup_address;
    cmd_d.refv    = in_i.reference_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

@@ rtl/acsf_fifo.sv @@
// Two-entry queue that decouples the front end from the executor.
// Depends on acsf_pkg for the entry type.
module acsf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  acsf_pkg::cmd_t  push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output acsf_pkg::cmd_t  pop_data_o
);

  acsf_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;
  logic           push;
  logic           pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/acsf_back.sv @@
// Executor: applies one classified event per cycle, while no result beat is stalled,
// to the call state and registers the result beat. Depends on acsf_pkg and acsf_out_if.
module acsf_back #(
  parameter int MAX_PARTIES = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  acsf_pkg::cmd_t  cmd_i,
  acsf_out_if.source      out_o
);

  localparam int PW = $clog2(MAX_PARTIES + 1);
  localparam logic [PW-1:0] MaxCnt = PW'(MAX_PARTIES);
  localparam logic [PW-1:0] OneCnt = PW'(1);

  logic [acsf_pkg::STATE_W-1:0] state_q, state_d;
  logic [PW-1:0]                party_q, party_d;
  logic                         constructed_q, constructed_d;
  logic                         destroyed_q, destroyed_d;
  logic [acsf_pkg::REF_W-1:0]   ref_q, ref_d;

  logic out_valid_q;
  logic pass, wrong, dup, fatal, dnow;
  logic pass_q, wrong_q, dup_q, fatal_q, dnow_q;
  logic take;
  logic active;

  assign cmd_ready_o = !out_valid_q || out_o.ready;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign active      = (state_q == acsf_pkg::ST_P2P_ACTIVE) ||
                       (state_q == acsf_pkg::ST_P2MP_ACTIVE) ||
                       (state_q == acsf_pkg::ST_P2MP_LIJ);

  always_comb begin
    state_d       = state_q;
    party_d       = party_q;
    constructed_d = constructed_q;
    destroyed_d   = destroyed_q;
    ref_d         = ref_q;
    pass  = 1'b0;
    wrong = 1'b0;
    dup   = 1'b0;
    fatal = 1'b0;
    dnow  = 1'b0;
    if (destroyed_q && !cmd_i.fatal_exempt) begin
      fatal = 1'b1;
    end else begin
      case (cmd_i.act)
        acsf_pkg::ACT_CONSTRUCT: begin
          if (!constructed_q) constructed_d = 1'b1;
          else dup = 1'b1;
        end
        acsf_pkg::ACT_DESTROY: begin
          if (state_q == acsf_pkg::ST_PREPARING || state_q == acsf_pkg::ST_REL_INIT ||
              state_q == acsf_pkg::ST_RELEASED) begin
            state_d     = acsf_pkg::ST_RELEASED;
            destroyed_d = 1'b1;
            dnow        = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_LEAF_ADD: begin
          if (party_q < MaxCnt) party_d = party_q + OneCnt;
          pass = 1'b1;
        end
        acsf_pkg::ACT_LEAF_REMOVE: begin
          if (party_q != '0) begin
            party_d = party_q - OneCnt;
            if (party_q == OneCnt) begin
              destroyed_d = 1'b1;
              dnow        = 1'b1;
            end
          end
        end
        acsf_pkg::ACT_LSR_RESPONSE: begin
          if (state_q == acsf_pkg::ST_LIJ_REQUESTED) begin
            ref_d   = cmd_i.refv;
            state_d = acsf_pkg::ST_IN_WAIT_LOCAL;
            pass    = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_LEAF_FAIL_IND: begin
          if (state_q == acsf_pkg::ST_LIJ_REQUESTED) begin
            state_d = acsf_pkg::ST_RELEASED;
            pass    = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_LEAF_SETUP_IND: begin
          if (state_q == acsf_pkg::ST_P2MP_ACTIVE) begin
            state_d = acsf_pkg::ST_P2MP_LIJ;
            pass    = 1'b1;
          end else if (state_q == acsf_pkg::ST_UNDERSPEC) begin
            state_d = acsf_pkg::ST_OUT_WAIT_REM;
            pass    = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_PROCEEDING_IND: begin
          if (state_q == acsf_pkg::ST_OUT_WAIT_REM) begin
            ref_d = cmd_i.refv;
            pass  = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_CONNECT_IND, acsf_pkg::ACT_CONNECT_REQ: begin
          if ((cmd_i.act == acsf_pkg::ACT_CONNECT_IND &&
               state_q == acsf_pkg::ST_OUT_WAIT_REM) ||
              (cmd_i.act == acsf_pkg::ACT_CONNECT_REQ &&
               state_q == acsf_pkg::ST_IN_WAIT_LOCAL)) begin
            // Point-to-multipoint wins when both attribute flags are set.
            if (cmd_i.p2mp) begin
              state_d = acsf_pkg::ST_P2MP_ACTIVE;
              pass    = 1'b1;
            end else if (cmd_i.p2p) begin
              state_d = acsf_pkg::ST_P2P_ACTIVE;
              pass    = 1'b1;
            end
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_RELEASE_IND: begin
          if (active) begin
            state_d = acsf_pkg::ST_RELEASED;
            pass    = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_REL_COMPLETE_IND: begin
          if (active || state_q == acsf_pkg::ST_OUT_WAIT_REM ||
              state_q == acsf_pkg::ST_REL_INIT) begin
            state_d = acsf_pkg::ST_RELEASED;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_LEAF_SETUP_REQ: begin
          if (state_q == acsf_pkg::ST_LIJ_PREPARING || state_q == acsf_pkg::ST_PREPARING) begin
            state_d = acsf_pkg::ST_LIJ_REQUESTED;
            pass    = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_LEAF_FAIL_REQ: begin
          if (state_q == acsf_pkg::ST_P2MP_ACTIVE || state_q == acsf_pkg::ST_P2MP_LIJ) begin
            pass = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_SETUP_REQ: begin
          if (state_q == acsf_pkg::ST_UNDERSPEC || state_q == acsf_pkg::ST_PREPARING) begin
            state_d = cmd_i.delayed ? acsf_pkg::ST_UNDERSPEC : acsf_pkg::ST_OUT_WAIT_REM;
            pass    = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_RELEASE_REQ: begin
          if (active) begin
            state_d = acsf_pkg::ST_REL_INIT;
            pass    = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_REL_COMPLETE_REQ: begin
          if (state_q == acsf_pkg::ST_OUT_WAIT_REM || state_q == acsf_pkg::ST_IN_WAIT_LOCAL ||
              state_q == acsf_pkg::ST_RELEASED) begin
            state_d = acsf_pkg::ST_RELEASED;
            pass    = 1'b1;
          end else wrong = 1'b1;
        end
        acsf_pkg::ACT_PASSTHROUGH: begin
          pass = 1'b1;
        end
        acsf_pkg::ACT_QUEUE_EMPTY: begin
          if (state_q == acsf_pkg::ST_P2MP_LIJ) state_d = acsf_pkg::ST_P2MP_ACTIVE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= acsf_pkg::ST_PREPARING;
      party_q       <= '0;
      constructed_q <= 1'b0;
      destroyed_q   <= 1'b0;
      ref_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        state_q       <= state_d;
        party_q       <= party_d;
        constructed_q <= constructed_d;
        destroyed_q   <= destroyed_d;
        ref_q         <= ref_d;
        out_valid_q   <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pass_q  <= pass;
      wrong_q <= wrong;
      dup_q   <= dup;
      fatal_q <= fatal;
      dnow_q  <= dnow;
    end
  end

  // The call state and reference registers double as the result fields.
  assign out_o.valid               = out_valid_q;
  assign out_o.call_state          = state_q;
  assign out_o.stored_reference    = ref_q;
  assign out_o.pass_on             = pass_q;
  assign out_o.wrong_state         = wrong_q;
  assign out_o.duplicate_construct = dup_q;
  assign out_o.fatal_after_destroy = fatal_q;
  assign out_o.destroyed_now       = dnow_q;

endmodule

@@ rtl/atm_call_signalling_fsm.sv @@
// ATM call signalling state machine, top level.
// An event beat passes the front register, then the queue, then the executor
// register before its result beat is presented.
// Throughput: one event per cycle while result beats are taken by the sink.
// Reset clears the call to the preparing state with zero party count, flags
// and call reference, empties the queue and clears the call identifier.
module atm_call_signalling_fsm #(
  parameter int MAX_PARTIES = 63
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [acsf_pkg::CID_W-1:0]    cfg_data_i,
  acsf_in_if.sink                       in_i,
  acsf_out_if.source                    out_o
);

  logic                       cmd_valid;
  logic                       cmd_ready;
  acsf_pkg::cmd_t             cmd;
  logic                       q_valid;
  logic                       q_ready;
  acsf_pkg::cmd_t             q_cmd;
  logic [acsf_pkg::CID_W-1:0] call_id_q;

  // The call identifier is held for reporting only; no result field uses it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      call_id_q <= '0;
    end else if (cfg_we_i) begin
      call_id_q <= cfg_data_i;
    end
  end

  acsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  acsf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  acsf_back #(
    .MAX_PARTIES (MAX_PARTIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_o       (out_o)
  );

endmodule
